// File: src/assert_macros.svh
// Assertion macros shared by the range prefix balance check RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off while rst is high.
`define RPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define RPB_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define RPB_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: src/rpb_pkg.sv
// Shared constants and types for the range prefix balance check.
package rpb_pkg;

  localparam int MAX_LENGTH  = 1024;
  localparam int BLOCK_SIZE  = 32;
  localparam int BLOCK_COUNT = (MAX_LENGTH + BLOCK_SIZE - 1) / BLOCK_SIZE;

  localparam int POS_W = 11;                     // position / length field width
  localparam int IDX_W = $clog2(MAX_LENGTH);     // zero-based symbol index
  localparam int OFF_W = $clog2(BLOCK_SIZE);     // symbol offset inside a block
  localparam int BLK_W = $clog2(BLOCK_COUNT);    // block id
  localparam int TOT_W = OFF_W + 2;              // block total, -BS..BS
  localparam int LST_W = OFF_W + 1;              // block least prefix, -BS..0
  localparam int SUM_W = TOT_W + LST_W;          // summary word
  localparam int ACC_W = IDX_W + 2;              // query accumulators

  localparam logic [POS_W-1:0] LEN_MAX = POS_W'(MAX_LENGTH);
  localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(BLOCK_COUNT - 1);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(BLOCK_SIZE - 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef struct packed {
    logic             op;
    logic [POS_W-1:0] pos;
    logic             plus;
    logic [POS_W-1:0] rstart;
    logic [POS_W-1:0] rend;
  } item_t;

  typedef struct packed {
    logic balanced;
    logic range_error;
  } res_t;

  typedef struct packed {
    logic                  re;
    logic                  we;
    logic [BLK_W-1:0]      addr;
    logic [BLOCK_SIZE-1:0] wdata;
  } sym_req_t;

  typedef struct packed {
    logic             re;
    logic             we;
    logic [BLK_W-1:0] addr;
    logic [SUM_W-1:0] wdata;
  } sum_req_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
    res_t res;
  } stat_t;

endpackage

// File: src/rpb_ram.sv
// Single-port synchronous RAM, registered read data.
module rpb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: src/rpb_ctrl.sv
// Sequencer: block rebuilds, updates and range walks over the two RAMs.
module rpb_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rpb_pkg::POS_W-1:0]    length,
  input  logic                         rebuild_start,
  input  logic                         item_start,
  input  rpb_pkg::item_t               item,
  input  logic                         res_take,
  output rpb_pkg::sym_req_t            sym_req,
  input  logic [rpb_pkg::BLOCK_SIZE-1:0] sym_rdata,
  output rpb_pkg::sum_req_t            sum_req,
  input  logic [rpb_pkg::SUM_W-1:0]    sum_rdata,
  output rpb_pkg::stat_t               stat
);

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RD    = 8'b0000_0100,
    S_LOAD  = 8'b0000_1000,
    S_WALK  = 8'b0001_0000,
    S_WSUM  = 8'b0010_0000,
    S_QSTEP = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic                          all_mode, all_mode_next;
  logic                          upd, upd_next;
  logic [rpb_pkg::BLK_W-1:0]     blk, blk_next;
  logic [rpb_pkg::OFF_W-1:0]     off, off_next;
  logic [rpb_pkg::OFF_W-1:0]     uoff, uoff_next;
  logic                          uplus, uplus_next;
  logic [rpb_pkg::BLOCK_SIZE-1:0] work_row, work_row_next;
  logic signed [rpb_pkg::TOT_W-1:0] wtot, wtot_next;
  logic signed [rpb_pkg::LST_W-1:0] wlst, wlst_next;
  logic [rpb_pkg::POS_W-1:0]     cur, cur_next;
  logic [rpb_pkg::POS_W-1:0]     qend, qend_next;
  logic signed [rpb_pkg::ACC_W-1:0] atot, atot_next;
  logic signed [rpb_pkg::ACC_W-1:0] alst, alst_next;
  rpb_pkg::res_t                 res, res_next;

  // item decode
  logic [rpb_pkg::IDX_W-1:0] pidx, sidx;
  logic                      pos_ok, q_err;

  // block walk
  logic signed [rpb_pkg::TOT_W-1:0] wtot_dec;
  logic                             in_use;
  logic [rpb_pkg::BLOCK_SIZE-1:0]   mod_row;

  // range walk
  logic [rpb_pkg::IDX_W-1:0]   qidx, nidx;
  logic [rpb_pkg::BLK_W-1:0]   qblk, nblk;
  logic [rpb_pkg::OFF_W-1:0]   qoff;
  logic [rpb_pkg::POS_W-1:0]   blk_hi, blk_last, qnext;
  logic                        full;
  logic signed [rpb_pkg::ACC_W-1:0] s_tot, s_lst, cand, atot_dec, q_tot, q_lst;

  assign pidx   = rpb_pkg::IDX_W'(item.pos - rpb_pkg::POS_W'(1));
  assign sidx   = rpb_pkg::IDX_W'(item.rstart - rpb_pkg::POS_W'(1));
  assign pos_ok = (item.pos != '0) && (item.pos <= length);
  assign q_err  = (item.rstart == '0) || (item.rend == '0) ||
                  (item.rstart > length) || (item.rend > length);

  assign wtot_dec = wtot - rpb_pkg::TOT_W'(1);
  assign in_use   = rpb_pkg::POS_W'({blk, off}) < length;

  always_comb begin
    mod_row       = sym_rdata;
    mod_row[uoff] = uplus;
  end

  // current step of a range walk
  assign qidx     = rpb_pkg::IDX_W'(cur - rpb_pkg::POS_W'(1));
  assign qblk     = rpb_pkg::BLK_W'(qidx >> rpb_pkg::OFF_W);
  assign qoff     = qidx[rpb_pkg::OFF_W-1:0];
  assign blk_hi   = (rpb_pkg::POS_W'(qblk) + rpb_pkg::POS_W'(1)) << rpb_pkg::OFF_W;
  assign blk_last = (blk_hi < length) ? blk_hi : length;
  assign full     = (qoff == '0) && (blk_last <= qend);
  assign s_tot    = {{(rpb_pkg::ACC_W - rpb_pkg::TOT_W){sum_rdata[rpb_pkg::SUM_W-1]}},
                     sum_rdata[rpb_pkg::SUM_W-1:rpb_pkg::LST_W]};
  assign s_lst    = {{(rpb_pkg::ACC_W - rpb_pkg::LST_W){sum_rdata[rpb_pkg::LST_W-1]}},
                     sum_rdata[rpb_pkg::LST_W-1:0]};
  assign cand     = atot + s_lst;
  assign atot_dec = atot - rpb_pkg::ACC_W'(1);

  always_comb begin
    if (full) begin
      q_tot = atot + s_tot;
      q_lst = (cand < alst) ? cand : alst;
      qnext = blk_last + rpb_pkg::POS_W'(1);
    end else if (sym_rdata[qoff]) begin
      q_tot = atot + rpb_pkg::ACC_W'(1);
      q_lst = alst;
      qnext = cur + rpb_pkg::POS_W'(1);
    end else begin
      q_tot = atot_dec;
      q_lst = (atot_dec < alst) ? atot_dec : alst;
      qnext = cur + rpb_pkg::POS_W'(1);
    end
  end

  assign nidx = rpb_pkg::IDX_W'(qnext - rpb_pkg::POS_W'(1));
  assign nblk = rpb_pkg::BLK_W'(nidx >> rpb_pkg::OFF_W);

  always_comb begin
    state_next    = state;
    all_mode_next = all_mode;
    upd_next      = upd;
    blk_next      = blk;
    off_next      = off;
    uoff_next     = uoff;
    uplus_next    = uplus;
    work_row_next = work_row;
    wtot_next     = wtot;
    wlst_next     = wlst;
    cur_next      = cur;
    qend_next     = qend;
    atot_next     = atot;
    alst_next     = alst;
    res_next      = res;
    sym_req       = '0;
    sum_req       = '0;
    sym_req.addr  = blk;
    sum_req.addr  = blk;

    unique case (state)
      S_INIT: begin
        // all symbols to plus one, row by row
        sym_req.we    = 1'b1;
        sym_req.wdata = '1;
        if (blk == rpb_pkg::BLK_LAST) begin
          blk_next      = '0;
          all_mode_next = 1'b1;
          upd_next      = 1'b0;
          state_next    = S_RD;
        end else begin
          blk_next = blk + rpb_pkg::BLK_W'(1);
        end
      end

      S_IDLE: begin
        if (rebuild_start) begin
          blk_next      = '0;
          all_mode_next = 1'b1;
          upd_next      = 1'b0;
          state_next    = S_RD;
        end else if (item_start) begin
          if (item.op == rpb_pkg::OP_WRITE) begin
            if (pos_ok) begin
              blk_next      = rpb_pkg::BLK_W'(pidx >> rpb_pkg::OFF_W);
              uoff_next     = pidx[rpb_pkg::OFF_W-1:0];
              uplus_next    = item.plus;
              all_mode_next = 1'b0;
              upd_next      = 1'b1;
              state_next    = S_RD;
            end
          end else if (q_err) begin
            res_next   = '{balanced: 1'b0, range_error: 1'b1};
            state_next = S_EMIT;
          end else if (item.rstart > item.rend) begin
            res_next   = '{balanced: 1'b1, range_error: 1'b0};
            state_next = S_EMIT;
          end else begin
            sym_req.re   = 1'b1;
            sum_req.re   = 1'b1;
            sym_req.addr = rpb_pkg::BLK_W'(sidx >> rpb_pkg::OFF_W);
            sum_req.addr = rpb_pkg::BLK_W'(sidx >> rpb_pkg::OFF_W);
            cur_next     = item.rstart;
            qend_next    = item.rend;
            atot_next    = '0;
            alst_next    = '0;
            state_next   = S_QSTEP;
          end
        end
      end

      S_RD: begin
        sym_req.re = 1'b1;
        state_next = S_LOAD;
      end

      S_LOAD: begin
        if (upd) begin
          sym_req.we    = 1'b1;
          sym_req.wdata = mod_row;
          work_row_next = mod_row;
        end else begin
          work_row_next = sym_rdata;
        end
        off_next   = '0;
        wtot_next  = '0;
        wlst_next  = '0;
        state_next = S_WALK;
      end

      S_WALK: begin
        // positions past the length in use do not count
        if (in_use) begin
          if (work_row[off]) begin
            wtot_next = wtot + rpb_pkg::TOT_W'(1);
          end else begin
            wtot_next = wtot_dec;
            if (wtot_dec < wlst) begin
              wlst_next = rpb_pkg::LST_W'(wtot_dec);
            end
          end
        end
        if (off == rpb_pkg::OFF_LAST) begin
          state_next = S_WSUM;
        end else begin
          off_next = off + rpb_pkg::OFF_W'(1);
        end
      end

      S_WSUM: begin
        sum_req.we    = 1'b1;
        sum_req.wdata = {wtot, wlst};
        if (all_mode && (blk != rpb_pkg::BLK_LAST)) begin
          blk_next   = blk + rpb_pkg::BLK_W'(1);
          state_next = S_RD;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_QSTEP: begin
        atot_next = q_tot;
        alst_next = q_lst;
        if (qnext > qend) begin
          res_next   = '{balanced: ~q_lst[rpb_pkg::ACC_W-1], range_error: 1'b0};
          state_next = S_EMIT;
        end else begin
          cur_next = qnext;
          // crossing into another block: fetch its row and summary now
          if (nblk != qblk) begin
            sym_req.re   = 1'b1;
            sum_req.re   = 1'b1;
            sym_req.addr = nblk;
            sum_req.addr = nblk;
          end
        end
      end

      S_EMIT: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      blk      <= '0;
      all_mode <= 1'b0;
      upd      <= 1'b0;
    end else begin
      state    <= state_next;
      blk      <= blk_next;
      all_mode <= all_mode_next;
      upd      <= upd_next;
    end
  end

  always_ff @(posedge clk) begin
    off      <= off_next;
    uoff     <= uoff_next;
    uplus    <= uplus_next;
    work_row <= work_row_next;
    wtot     <= wtot_next;
    wlst     <= wlst_next;
    cur      <= cur_next;
    qend     <= qend_next;
    atot     <= atot_next;
    alst     <= alst_next;
    res      <= res_next;
  end

  assign stat.idle      = (state == S_IDLE);
  assign stat.res_valid = (state == S_EMIT);
  assign stat.res       = res;

`include "assert_macros.svh"

  `RPB_ASSERT(a_sym_port, !(sym_req.we && sym_req.re), "symbol RAM read and write together")
  `RPB_ASSERT_IMP(a_qstep_range, state == S_QSTEP, (cur != '0) && (cur <= qend), "walk past range end")
  `RPB_ASSERT_NXT(a_walk_end, (state == S_WALK) && (off == rpb_pkg::OFF_LAST), state == S_WSUM, "block walk did not store summary")

endmodule

// File: src/range_prefix_balance_check.sv
// Top level of the range prefix balance check: ports, length register, result register.
//
//  channel | dir | handshake              | word contents
//  --------+-----+------------------------+-----------------------------------------------
//  s_axis  | in  | s_axis_tvalid/tready   | tuser: operation; tdata: position, symbol_is_plus,
//          |     |                        |   range_start, range_end
//  m_axis  | out | m_axis_tvalid/tready   | tdata: balanced; tuser: range_error
//  cfg     | in  | cfg_valid/cfg_ready    | cfg_data: length_in_use
//
// Update: row read, write-back, 32-step block walk, summary store.
// Query: one step per single symbol and one per whole block; bad bounds and empty
//   ranges answer without a walk.
// After reset: row fill of all 32 blocks, then a full rebuild of 32 blocks before
//   s_axis_tready rises. Each cfg write runs the same rebuild.
// A query result sits in the m_axis register; the next word is taken while it waits,
//   and a second result stalls in the sequencer until m_axis drains.
module range_prefix_balance_check (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [10:0] position, [11] symbol_is_plus, [22:12] range_start, [33:23] range_end, rest 0
  input  logic [39:0]               s_axis_tdata,
  // [0] operation
  input  logic [0:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [0] balanced, rest 0
  output logic [7:0]                m_axis_tdata,
  // [0] range_error
  output logic [0:0]                m_axis_tuser,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rpb_pkg::POS_W-1:0] cfg_data
);

  logic [rpb_pkg::POS_W-1:0] length;
  logic [rpb_pkg::POS_W-1:0] cfg_sat;
  logic                      cfg_fire;
  logic                      in_fire;
  logic                      res_take;
  rpb_pkg::item_t            item;
  rpb_pkg::stat_t            stat;
  rpb_pkg::sym_req_t         sym_req;
  rpb_pkg::sum_req_t         sum_req;
  logic [rpb_pkg::BLOCK_SIZE-1:0] sym_rdata;
  logic [rpb_pkg::SUM_W-1:0]      sum_rdata;

  // config wins over an item offered in the same cycle
  assign cfg_ready     = stat.idle;
  assign cfg_fire      = cfg_valid && cfg_ready;
  assign s_axis_tready = stat.idle && !cfg_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // length saturates to 1..MAX_LENGTH
  always_comb begin
    if (cfg_data == '0) begin
      cfg_sat = rpb_pkg::POS_W'(1);
    end else if (cfg_data > rpb_pkg::LEN_MAX) begin
      cfg_sat = rpb_pkg::LEN_MAX;
    end else begin
      cfg_sat = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= rpb_pkg::LEN_MAX;
    end else if (cfg_fire) begin
      length <= cfg_sat;
    end
  end

  assign item.op     = s_axis_tuser[0];
  assign item.pos    = s_axis_tdata[10:0];
  assign item.plus   = s_axis_tdata[11];
  assign item.rstart = s_axis_tdata[22:12];
  assign item.rend   = s_axis_tdata[33:23];

  rpb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .length        (length),
    .rebuild_start (cfg_fire),
    .item_start    (in_fire),
    .item          (item),
    .res_take      (res_take),
    .sym_req       (sym_req),
    .sym_rdata     (sym_rdata),
    .sum_req       (sum_req),
    .sum_rdata     (sum_rdata),
    .stat          (stat)
  );

  // one row of symbols per block
  rpb_ram #(
    .WIDTH (rpb_pkg::BLOCK_SIZE),
    .DEPTH (rpb_pkg::BLOCK_COUNT)
  ) u_sym_ram (
    .clk   (clk),
    .we    (sym_req.we),
    .re    (sym_req.re),
    .addr  (sym_req.addr),
    .wdata (sym_req.wdata),
    .rdata (sym_rdata)
  );

  // {total, least prefix} per block
  rpb_ram #(
    .WIDTH (rpb_pkg::SUM_W),
    .DEPTH (rpb_pkg::BLOCK_COUNT)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_req.we),
    .re    (sum_req.re),
    .addr  (sum_req.addr),
    .wdata (sum_req.wdata),
    .rdata (sum_rdata)
  );

  // output register: loads whenever it is empty or being drained
  assign res_take = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= stat.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && stat.res_valid) begin
      m_axis_tdata <= {7'b0, stat.res.balanced};
      m_axis_tuser <= stat.res.range_error;
    end
  end

`include "assert_macros.svh"

  `RPB_ASSERT_NXT(a_cfg_rebuild, cfg_valid && cfg_ready, !stat.idle, "config write did not start rebuild")

endmodule
